// File: rtl/rpgf_pkg.sv
// Shared types and constants for the residue product grid filter.
// No dependencies; every other file imports this package.
package rpgf_pkg;

	localparam int MAX_CLASSES_DEF = 64;
	localparam int N_W             = 64;
	localparam int MOD_W           = 9;
	localparam int CLS_W           = 8;
	localparam int IDX_W           = 6;
	localparam int CNT_W           = 7;
	localparam int SURV_W          = 13;
	localparam int MASK_W          = 64;
	localparam int PROD_W          = 2 * CLS_W;
	localparam int OUT_DATA_W      = 104;

	localparam logic [MOD_W-1:0] MAX_MODULUS   = 9'd256;
	localparam logic [MOD_W-1:0] MODULUS_RESET = 9'd30;

	// Per-cell control carried alongside the data through the pipeline
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx_i;
		logic [IDX_W-1:0] idx_j;
		logic [MOD_W-1:0] target;
		logic             first;
		logic             row_end;
		logic             item_last;
	} cell_meta_t;

endpackage

// File: rtl/rpgf_modn.sv
// Bit-serial remainder of the 64-bit input value by the modulus.
// Depends on rpgf_pkg.
module rpgf_modn
	import rpgf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [N_W-1:0]   n,
	input  logic [MOD_W-1:0] modulus,
	output logic             busy,
	output logic [MOD_W-1:0] rem
);

	logic [N_W-1:0]   shift_q;
	logic [MOD_W-1:0] rem_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic [MOD_W:0]   rem_sh;
	logic [MOD_W-1:0] rem_nxt;

	// Bring in one dividend bit and subtract the modulus once if it fits
	always_comb begin
		rem_sh  = {rem_q, shift_q[N_W-1]};
		rem_nxt = rem_sh[MOD_W-1:0];
		if (rem_sh >= {1'b0, modulus}) begin
			rem_nxt = MOD_W'(rem_sh - {1'b0, modulus});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'(N_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= n;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[N_W-2:0], 1'b0};
			rem_q   <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// File: rtl/rpgf_gcd.sv
// Subtractive gcd unit, one subtraction per cycle; reports whether gcd is one.
// Depends on rpgf_pkg.
module rpgf_gcd
	import rpgf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MOD_W-1:0] a_in,
	input  logic [MOD_W-1:0] b_in,
	output logic             done,
	output logic             coprime
);

	logic [MOD_W-1:0] a_q;
	logic [MOD_W-1:0] b_q;
	logic             busy_q;
	logic             done_q;
	logic             coprime_q;

	// Reduce the larger operand until one is zero or both match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			coprime_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				a_q    <= a_in;
				b_q    <= b_in;
			end else if (busy_q) begin
				if (a_q == '0) begin
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
					coprime_q <= (b_q == MOD_W'(1));
				end else if (a_q == b_q) begin
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
					coprime_q <= (a_q == MOD_W'(1));
				end else if (a_q > b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
		end
	end

	assign done    = done_q;
	assign coprime = coprime_q;

endmodule

// File: rtl/rpgf_cell_pipe.sv
// Cell pipeline: class product, four-stage modular reduction, target compare.
// Depends on rpgf_pkg.
module rpgf_cell_pipe
	import rpgf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [MOD_W-1:0] modulus,
	input  cell_meta_t       meta_s1,
	input  logic [CLS_W-1:0] ci_s1,
	input  logic [CLS_W-1:0] cj_s1,
	output cell_meta_t       meta_out,
	output logic [CLS_W-1:0] ci_out,
	output logic             hit_out
);

	// Four restoring steps of remainder by the modulus
	function automatic logic [MOD_W-1:0] step4(input logic [MOD_W-1:0] rem_in,
		input logic [3:0] bits, input logic [MOD_W-1:0] m);
		logic [MOD_W-1:0] r;
		logic [MOD_W:0]   t;
		r = rem_in;
		for (int k = 3; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
			end
			r = t[MOD_W-1:0];
		end
		return r;
	endfunction

	cell_meta_t       meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic [CLS_W-1:0] ci_s2, ci_s3, ci_s4, ci_s5, ci_s6;
	logic [PROD_W-1:0] prod_s2, prod_s3, prod_s4, prod_s5;
	logic [MOD_W-1:0] rem_s3, rem_s4, rem_s5;
	logic             hit_s6;

	// Advance the cell control, valid bits included, together with the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
		end else if (adv) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ci_s2   <= ci_s1;
			ci_s3   <= ci_s2;
			ci_s4   <= ci_s3;
			ci_s5   <= ci_s4;
			ci_s6   <= ci_s5;
			// Multiply, then reduce four product bits per stage
			prod_s2 <= ci_s1 * cj_s1;
			prod_s3 <= prod_s2;
			prod_s4 <= prod_s3;
			prod_s5 <= prod_s4;
			rem_s3  <= step4('0, prod_s2[15:12], modulus);
			rem_s4  <= step4(rem_s3, prod_s3[11:8], modulus);
			rem_s5  <= step4(rem_s4, prod_s4[7:4], modulus);
			hit_s6  <= (step4(rem_s5, prod_s5[3:0], modulus) == meta_s5.target);
		end
	end

	assign meta_out = meta_s6;
	assign ci_out   = ci_s6;
	assign hit_out  = hit_s6;

endmodule

// File: rtl/rpgf_row_acc.sv
// Row accumulator and output register: builds each row mask and running count.
// Depends on rpgf_pkg.
module rpgf_row_acc
	import rpgf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_meta_t            meta,
	input  logic [CLS_W-1:0]      ci,
	input  logic                  hit,
	input  logic [CNT_W-1:0]      class_count,
	input  logic                  overflow,
	input  logic                  m_tready,
	output logic                  adv,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]            m_tuser,
	output logic                  m_tlast
);

	logic [MASK_W-1:0] mask_q, mask_nxt;
	logic [SURV_W-1:0] count_q, count_nxt;
	logic              out_valid_q;

	assign adv = !out_valid_q || m_tready;

	// Merge this cell into the row being built
	always_comb begin
		mask_nxt  = (meta.idx_j == '0) ? '0 : mask_q;
		if (hit) begin
			mask_nxt = mask_nxt | (MASK_W'(1) << meta.idx_j);
		end
		count_nxt = (meta.first ? '0 : count_q) + SURV_W'(hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta.valid && meta.row_end;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && meta.valid) begin
			mask_q  <= mask_nxt;
			count_q <= count_nxt;
			if (meta.row_end) begin
				m_tdata <= {6'd0, count_nxt, class_count, mask_nxt, ci, meta.idx_i};
				m_tuser <= overflow;
				m_tlast <= meta.item_last;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: rtl/residue_product_grid_filter.sv
// Residue product grid filter. After a modulus write, the first input item
// rebuilds the table of residues coprime to the modulus with a subtractive gcd
// unit, one residue after another. Each input then goes through the serial
// remainder unit to find n mod modulus, and issues its class_count * class_count
// grid cells into a six-stage pipeline at one cell per cycle while the output
// side does not stall it. One row result per grid row leaves on the master side;
// the next input is taken once the last cell of the previous one has been issued.
module residue_product_grid_filter
	import rpgf_pkg::*;
#(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Modulus register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MOD_W-1:0]      cfg_data,
	// Input: [63:0] n
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [N_W-1:0]        s_tdata,
	// Output: [5:0] row_index, [13:6] row_class, [77:14] row_mask,
	// [84:78] class_count, [97:85] survivors, [103:98] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [0] table_overflow
	output logic [0:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD_GO,
		ST_GCD_WAIT,
		ST_WAIT_DIV,
		ST_ISSUE
	} state_t;

	state_t           state_q;
	logic [MOD_W-1:0] modulus_q;
	logic             table_valid_q;
	logic [CNT_W-1:0] size_q;
	logic             overflow_q;
	logic [MOD_W-1:0] r_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic [CLS_W-1:0] class_mem [MAX_CLASSES];
	logic [CLS_W-1:0] ci_s1, cj_s1;
	cell_meta_t       meta_s1, meta_pipe;
	logic [CLS_W-1:0] ci_pipe;
	logic             hit_pipe;
	logic             adv;
	logic             in_xfer, cfg_xfer;
	logic             div_busy;
	logic [MOD_W-1:0] div_rem;
	logic             gcd_done, gcd_coprime;
	logic             mem_we;
	logic             last_j, last_i;
	logic [MOD_W-1:0] cfg_clamped;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign mem_we    = (state_q == ST_GCD_WAIT) && gcd_done && gcd_coprime
		&& (size_q < CNT_W'(MAX_CLASSES));
	assign last_j    = ({1'b0, j_q} == size_q - CNT_W'(1));
	assign last_i    = ({1'b0, i_q} == size_q - CNT_W'(1));

	// Hold the modulus in 1..MAX_MODULUS
	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data == '0) begin
			cfg_clamped = MOD_W'(1);
		end else if (cfg_data > MAX_MODULUS) begin
			cfg_clamped = MAX_MODULUS;
		end
	end

	rpgf_modn u_modn (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_xfer),
		.n       (s_tdata),
		.modulus (modulus_q),
		.busy    (div_busy),
		.rem     (div_rem)
	);

	rpgf_gcd u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_GCD_GO),
		.a_in    (r_q),
		.b_in    (modulus_q),
		.done    (gcd_done),
		.coprime (gcd_coprime)
	);

	// Sequencer: table rebuild, remainder wait, cell issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			modulus_q     <= MODULUS_RESET;
			table_valid_q <= 1'b0;
			size_q        <= '0;
			overflow_q    <= 1'b0;
			r_q           <= '0;
			i_q           <= '0;
			j_q           <= '0;
			meta_s1       <= '0;
		end else begin
			if (cfg_xfer) begin
				modulus_q     <= cfg_clamped;
				table_valid_q <= 1'b0;
			end
			if (adv) begin
				meta_s1.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (table_valid_q) begin
							state_q <= ST_WAIT_DIV;
						end else begin
							r_q        <= '0;
							size_q     <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_GCD_GO;
						end
					end
				end
				ST_GCD_GO: begin
					state_q <= ST_GCD_WAIT;
				end
				ST_GCD_WAIT: begin
					if (gcd_done) begin
						if (gcd_coprime) begin
							if (size_q < CNT_W'(MAX_CLASSES)) begin
								size_q <= size_q + CNT_W'(1);
							end else begin
								overflow_q <= 1'b1;
							end
						end
						if (r_q == modulus_q - MOD_W'(1)) begin
							table_valid_q <= 1'b1;
							state_q       <= ST_WAIT_DIV;
						end else begin
							r_q     <= r_q + MOD_W'(1);
							state_q <= ST_GCD_GO;
						end
					end
				end
				ST_WAIT_DIV: begin
					if (!div_busy) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (adv) begin
						meta_s1.valid     <= 1'b1;
						meta_s1.idx_i     <= i_q;
						meta_s1.idx_j     <= j_q;
						meta_s1.target    <= div_rem;
						meta_s1.first     <= (i_q == '0) && (j_q == '0);
						meta_s1.row_end   <= last_j;
						meta_s1.item_last <= last_j && last_i;
						if (last_j) begin
							j_q <= '0;
							i_q <= i_q + IDX_W'(1);
							if (last_i) begin
								state_q <= ST_IDLE;
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Class table: written during rebuild, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			class_mem[size_q[AW-1:0]] <= r_q[CLS_W-1:0];
		end
		if (adv) begin
			ci_s1 <= class_mem[i_q[AW-1:0]];
			cj_s1 <= class_mem[j_q[AW-1:0]];
		end
	end

	rpgf_cell_pipe u_cell_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.modulus  (modulus_q),
		.meta_s1  (meta_s1),
		.ci_s1    (ci_s1),
		.cj_s1    (cj_s1),
		.meta_out (meta_pipe),
		.ci_out   (ci_pipe),
		.hit_out  (hit_pipe)
	);

	rpgf_row_acc u_row_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.meta        (meta_pipe),
		.ci          (ci_pipe),
		.hit         (hit_pipe),
		.class_count (size_q),
		.overflow    (overflow_q),
		.m_tready    (m_tready),
		.adv         (adv),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for residue_product_grid_filter.
// Depends on rpgf_pkg and the RTL top; predicts each row transfer in place and
// drives random idling on the input and output channels.
`timescale 1ns / 100ps

module tb
	import rpgf_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_ITEMS   = 120;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [CLS_W-1:0]  cls;
		logic [MASK_W-1:0] mask;
		logic [CNT_W-1:0]  cnt;
		logic [SURV_W-1:0] surv;
		logic              ovf;
		logic              last;
	} grid_row_t;

	typedef struct {
		row_kind_t   kind;
		logic [63:0] value;
		bit          typed;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MOD_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [N_W-1:0]        s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;

	// Wheel model state
	int unsigned     wheel_mod;
	int unsigned     wheel_classes[MAX_CLASSES_DEF];
	int unsigned     wheel_size;
	bit              wheel_fresh;
	bit              wheel_ovf;
	grid_row_t       pending_rows[$];
	int              errors;
	int              idle_cycles;
	bit              no_gaps;
	int              rx_hold;

	residue_product_grid_filter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Clamp a modulus write the way the register holds it
	function automatic void wheel_write(input logic [MOD_W-1:0] v);
		int unsigned m;
		m = 32'(v);
		if (m == 0) m = 1;
		if (m > 32'(MAX_MODULUS)) m = 32'(MAX_MODULUS);
		wheel_mod   = m;
		wheel_fresh = 1'b0;
	endfunction

	function automatic int unsigned gcd_of(input int unsigned a, input int unsigned b);
		int unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Rebuild the coprime class table if stale, then compute every grid row for n
	task automatic wheel_rows(input logic [63:0] n, output grid_row_t rows[$]);
		int unsigned target;
		int unsigned total;
		grid_row_t   r;
		rows = {};
		if (!wheel_fresh) begin
			wheel_size = 0;
			wheel_ovf  = 1'b0;
			for (int unsigned k = 0; k < wheel_mod; k++) begin
				if (gcd_of(k, wheel_mod) == 1) begin
					if (wheel_size < MAX_CLASSES_DEF) begin
						wheel_classes[wheel_size] = k;
						wheel_size++;
					end else begin
						wheel_ovf = 1'b1;
					end
				end
			end
			wheel_fresh = 1'b1;
		end
		target = 32'(n % 64'(wheel_mod));
		total  = 0;
		for (int unsigned i = 0; i < wheel_size; i++) begin
			r.mask = '0;
			for (int unsigned j = 0; j < wheel_size; j++) begin
				if ((wheel_classes[i] * wheel_classes[j]) % wheel_mod == target) begin
					r.mask[j] = 1'b1;
					total++;
				end
			end
			r.idx  = i[IDX_W-1:0];
			r.cls  = wheel_classes[i][CLS_W-1:0];
			r.cnt  = wheel_size[CNT_W-1:0];
			r.surv = total[SURV_W-1:0];
			r.ovf  = wheel_ovf;
			r.last = (i + 1 == wheel_size);
			rows.push_back(r);
		end
	endtask

	// Mostly back-to-back or short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic [63:0] n, input bit typed);
		int        gap;
		grid_row_t rows[$];
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= n;
		do @(posedge clk); while (!s_tready);
		wheel_rows(n, rows);
		// Modulus one: a single class 0 whose every cell matches
		if (typed) begin
			rows = {};
			rows.push_back('{idx: 0, cls: 0, mask: 64'd1, cnt: 7'd1, surv: 13'd1,
				ovf: 1'b0, last: 1'b1});
		end
		foreach (rows[k]) pending_rows.push_back(rows[k]);
	endtask

	// Drain all rows, let the pipeline settle, then write the modulus
	task automatic write_modulus(input logic [MOD_W-1:0] v);
		s_tvalid <= 1'b0;
		wait (pending_rows.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		wheel_write(v);
	endtask

	function automatic void check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Output side: random stall, row check and watchdog
	always @(posedge clk) begin
		grid_row_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_rows.size() == 0) begin
					$error("row transfer with nothing expected");
					errors++;
				end else begin
					e = pending_rows.pop_front();
					check_field("row_index", e.idx, m_tdata[5:0]);
					check_field("row_class", e.cls, m_tdata[13:6]);
					check_field("row_mask", e.mask, m_tdata[77:14]);
					check_field("class_count", e.cnt, m_tdata[84:78]);
					check_field("survivors", e.surv, m_tdata[97:85]);
					check_field("table_overflow", e.ovf, m_tuser[0]);
					check_field("last", e.last, m_tlast);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
			end else begin
				m_tready <= no_gaps || ($urandom_range(0, 3) != 0);
				rx_hold  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
		end
	end

	initial begin
		stim_row_t   directed[$];
		int          sent;
		int          phase_items;
		int unsigned m;
		logic [63:0] n;
		logic [MOD_W-1:0] mv;

		errors      = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		rx_hold     = 0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		wheel_write(MODULUS_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		directed = '{
			'{ROW_ITEM, 64'd0, 0},                  // reset modulus, first rebuild
			'{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 0},
			'{ROW_ITEM, 64'd1, 0},
			'{ROW_ITEM, 64'd7, 0},
			'{ROW_ITEM, 64'd29, 0},
			'{ROW_CFG,  64'd0, 0},                  // zero is held as one
			'{ROW_ITEM, 64'd0, 1},
			'{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 1},
			'{ROW_CFG,  64'd1, 0},                  // same value again, rebuild
			'{ROW_ITEM, 64'd5, 1},
			'{ROW_CFG,  64'h1FF, 0},                // saturates, table overflows
			'{ROW_ITEM, 64'd1, 0},
			'{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 0},
			'{ROW_CFG,  64'd256, 0},
			'{ROW_ITEM, 64'd0, 0},
			'{ROW_CFG,  64'd2, 0},
			'{ROW_ITEM, 64'd1, 0},
			'{ROW_ITEM, 64'd0, 0},
			'{ROW_CFG,  64'd97, 0},                 // prime, 96 classes, overflow
			'{ROW_ITEM, 64'd96, 0}
		};
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG)
				write_modulus(directed[k].value[MOD_W-1:0]);
			else
				send_item(directed[k].value, directed[k].typed);
		end

		// Random phases: mostly small moduli, a few large ones with short runs
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mv = ($urandom_range(0, 99) < 15) ? MOD_W'($urandom_range(0, 511))
				: MOD_W'($urandom_range(1, 48));
			write_modulus(mv);
			no_gaps     = ($urandom_range(0, 4) == 0);
			m           = wheel_mod;
			phase_items = (m > 96) ? 3 : 16;
			repeat (phase_items) begin
				case ($urandom_range(0, 3))
					0: n = {$urandom, $urandom};
					1: n = 64'($urandom_range(0, m - 1));
					default: n = 64'($urandom_range(0, m - 1) * $urandom_range(0, m - 1))
						+ 64'(m) * {32'd0, $urandom};
				endcase
				send_item(n, 1'b0);
				sent++;
			end
		end

		s_tvalid <= 1'b0;
		wait (pending_rows.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: residue_product_grid_filter.f
rtl/rpgf_pkg.sv
rtl/rpgf_modn.sv
rtl/rpgf_gcd.sv
rtl/rpgf_cell_pipe.sv
rtl/rpgf_row_acc.sv
rtl/residue_product_grid_filter.sv
tb/tb.sv
